// ===== hdl/assert_macros.svh =====
// Assertion macros for the timing wheel slot bank RTL.
// Included by twps_back, which carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/twps_pkg.sv =====
// Package for the timing wheel slot bank: opcodes, status codes, sizes.
// Used by the front, back and core modules; no dependencies.
package twps_pkg;
  localparam int NumSlotsDef  = 16;
  localparam int SlotDepthDef = 16;
  localparam int TagW  = 16;
  localparam int PrioW = 4;
  localparam int TimeW = 32;
  localparam int EntryW = TagW + PrioW + TimeW;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_CLRALL = 3'd2,
    OP_NEAR   = 3'd3,
    OP_EMPTY  = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic CFG_TOP = 1'b0;
  localparam logic CFG_BOT = 1'b1;

  // classified command from front to back
  typedef struct packed {
    logic [2:0]       opcode;
    logic             idx_ok;
    logic [7:0]       slot;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] due;
  } cmd_t;
endpackage

// ===== hdl/twps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module twps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/twps_front.sv =====
// Front part: accepts transactions, checks slot index, queues commands.
// Depends on twps_pkg.
module twps_front
  import twps_pkg::*;
#(
  parameter int NumSlots = NumSlotsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [3:0]        slot_index,
  input  logic [TagW-1:0]   task_tag,
  input  logic [PrioW-1:0]  task_priority,
  input  logic [TimeW-1:0]  due_time,
  output logic              q_valid,
  input  logic              q_ready,
  output cmd_t              q_cmd
);
  cmd_t       slot0, slot1;
  logic [1:0] cnt;
  logic       push, pop;
  cmd_t       c;

  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = slot0;

  always_comb begin
    c.opcode = opcode;
    c.idx_ok = ({5'd0, slot_index} < 9'(NumSlots));
    c.slot   = 8'(slot_index);
    c.tag    = task_tag;
    c.prio   = task_priority;
    c.due    = due_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (pop) begin
      slot0 <= (cnt == 2'd2) ? slot1 : c;
    end else if (push && cnt == 2'd0) begin
      slot0 <= c;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2))) begin
      slot1 <= c;
    end
  end
endmodule

// ===== hdl/twps_back.sv =====
// Back part: sequencer over the entry RAM and per-slot fill counts.
// Depends on twps_pkg, twps_ram and assert_macros.svh.
`include "assert_macros.svh"
module twps_back
  import twps_pkg::*;
#(
  parameter int NumSlots  = NumSlotsDef,
  parameter int SlotDepth = SlotDepthDef
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  input  logic [PrioW-1:0] top_prio,
  input  logic [PrioW-1:0] bot_prio,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             found,
  output logic [TagW-1:0]  nearest_tag,
  output logic             slot_is_empty,
  output logic [8:0]       total_count
);
  localparam int SW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int DW = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int FW = $clog2(SlotDepth + 1);
  localparam int AW = $clog2(NumSlots * SlotDepth) > 0 ? $clog2(NumSlots * SlotDepth) : 1;
  localparam int RD = (1 << AW);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_NEAR  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  cmd_t   cmd;
  logic [FW-1:0] fill [NumSlots];
  logic [8:0]    total;
  logic [FW-1:0] pos, n, rptr;
  logic          rvalid;
  logic [SW-1:0] cur_slot;
  logic [EntryW-1:0] best;
  logic          have_best;
  logic [DW-1:0] rlast;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [SW-1:0]     cslot;
  logic [TagW-1:0]   rtag;
  logic [PrioW-1:0]  rprio;
  logic [TimeW-1:0]  rtime;

  assign cslot = cmd.slot[SW-1:0];
  assign {rtag, rprio, rtime} = rdata;

  function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [FW-1:0] p);
    logic [AW+FW:0] a;
    a = (AW + FW + 1)'(s) * (AW + FW + 1)'(SlotDepth) + (AW + FW + 1)'(p);
    return a[AW-1:0];
  endfunction

  twps_ram #(.Width(EntryW), .Depth(RD)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign q_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign total_count = total;
  assign n = fill[cslot];

  always_comb begin
    we = 1'b0;
    waddr = addr_of(cslot, pos);
    wdata = {cmd.tag, cmd.prio, cmd.due};
    raddr = addr_of((state == S_NEAR) ? cur_slot : cslot, rptr);
    if (state == S_SHIFT) begin
      // move entry pos-1 up to pos
      we = rvalid;
      waddr = addr_of(cslot, pos);
      wdata = rdata;
    end else if (state == S_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= 9'd0;
      for (int i = 0; i < NumSlots; i++) fill[i] <= '0;
      rvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            status <= ST_OK;
            found <= 1'b0;
            nearest_tag <= '0;
            slot_is_empty <= 1'b0;
            rvalid <= 1'b0;
            state <= S_OUT;
            unique case (q_cmd.opcode)
              OP_INSERT: begin
                if (!q_cmd.idx_ok) status <= ST_BAD;
                else state <= S_SCAN;
              end
              OP_CLEAR: begin
                if (!q_cmd.idx_ok) status <= ST_BAD;
                else begin
                  total <= total - 9'(fill[q_cmd.slot[SW-1:0]]);
                  fill[q_cmd.slot[SW-1:0]] <= '0;
                end
              end
              OP_CLRALL: begin
                total <= 9'd0;
                for (int i = 0; i < NumSlots; i++) fill[i] <= '0;
              end
              OP_NEAR: begin
                cur_slot <= '0;
                rptr <= '0;
                have_best <= 1'b0;
                state <= S_NEAR;
              end
              OP_EMPTY: begin
                if (!q_cmd.idx_ok) status <= ST_BAD;
                else slot_is_empty <= (fill[q_cmd.slot[SW-1:0]] == '0);
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (n >= FW'(SlotDepth)) begin
            status <= ST_FULL;
            state <= S_OUT;
          end else if (cmd.prio == top_prio) begin
            pos <= n;
            state <= S_WRITE;
          end else if (cmd.prio == bot_prio) begin
            state <= (n == '0) ? S_WRITE : S_SHIFT;
            pos <= n;
            rptr <= n - FW'(1);
            rvalid <= 1'b0;
            rlast <= '0;
          end else begin
            pos <= '0;
            rptr <= '0;
            rvalid <= 1'b0;
            state <= (n == '0) ? S_WRITE : S_FIND;
          end
        end
        S_FIND: begin
          // linear search for first greater priority
          if (!rvalid) begin
            rvalid <= 1'b1;
            rptr <= rptr + FW'(1);
          end else if (cmd.prio < rprio) begin
            rlast <= pos[DW-1:0];
            pos <= n;
            rptr <= n - FW'(1);
            rvalid <= 1'b0;
            state <= S_SHIFT;
          end else if (pos + FW'(1) == n) begin
            pos <= n;
            state <= S_WRITE;
          end else begin
            pos <= pos + FW'(1);
            rptr <= rptr + FW'(1);
          end
        end
        S_SHIFT: begin
          // rptr leads pos by one read; walk down to the insert point
          if (!rvalid) begin
            rvalid <= 1'b1;
            rptr <= rptr - FW'(1);
          end else begin
            pos <= pos - FW'(1);
            rptr <= rptr - FW'(1);
            if (pos - FW'(1) == FW'(rlast)) begin
              rvalid <= 1'b0;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          fill[cslot] <= n + FW'(1);
          total <= total + 9'd1;
          state <= S_OUT;
        end
        S_NEAR: begin
          if (fill[cur_slot] == '0) begin
            if (32'(cur_slot) == NumSlots - 1) state <= S_OUT;
            else cur_slot <= cur_slot + SW'(1);
          end else if (!rvalid) begin
            rvalid <= 1'b1;
            rptr <= rptr + FW'(1);
          end else begin
            if (!have_best || rtime < best[TimeW-1:0]) begin
              best <= rdata;
              nearest_tag <= rtag;
            end
            have_best <= 1'b1;
            rptr <= rptr + FW'(1);
            if (rptr == fill[cur_slot]) begin
              found <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_idle, clk, rst, out_valid, !q_ready)
  `ASSERT_IMPL(a_total_bound, clk, rst, 1'b1, total <= 9'(NumSlots * SlotDepth))
  `ASSERT_NEXT(a_write_grows, clk, rst, state == S_WRITE && total < 9'd511, total == $past(total) + 9'd1)
endmodule

// ===== hdl/timing_wheel_priority_slots_core.sv =====
// Timing wheel slot bank with priority-ordered lists: one result per operation.
// Clear, empty query, bad index answer from idle; full slot from scan; insert ends in write.
// Nearest task skips empty slots, reads all entries of the first filled one, else walks all.
// Throughput: one operation at a time in the back sequencer; a 2-entry queue feeds it.
// Reset: synchronous, clears fill counts, total and priority registers to 15 and 0.
// Depends on twps_pkg, twps_front, twps_back, twps_ram.
module timing_wheel_priority_slots_core
  import twps_pkg::*;
#(
  parameter int NumSlots  = NumSlotsDef,
  parameter int SlotDepth = SlotDepthDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [PrioW-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [3:0]        slot_index,
  input  logic [TagW-1:0]   task_tag,
  input  logic [PrioW-1:0]  task_priority,
  input  logic [TimeW-1:0]  due_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              found,
  output logic [TagW-1:0]   nearest_tag,
  output logic              slot_is_empty,
  output logic [8:0]        total_count
);
  logic [PrioW-1:0] top_prio, bot_prio;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_prio <= 4'd15;
      bot_prio <= 4'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOP) top_prio <= cfg_data;
      else bot_prio <= cfg_data;
    end
  end

  twps_front #(.NumSlots(NumSlots)) u_front (
    .clk, .rst, .in_valid, .in_ready, .opcode, .slot_index, .task_tag,
    .task_priority, .due_time, .q_valid, .q_ready, .q_cmd
  );

  twps_back #(.NumSlots(NumSlots), .SlotDepth(SlotDepth)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .top_prio, .bot_prio,
    .out_valid, .out_ready, .status, .found, .nearest_tag, .slot_is_empty, .total_count
  );
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for timing_wheel_priority_slots_core: slot inserts, clears and queries.
// Holds a scoreboard class with its own slot-bank predictor; drives valid/ready channels.
// Depends on twps_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
  import twps_pkg::*;

  localparam int NumSlots  = 16;
  localparam int SlotDepth = 16;
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  typedef struct {
    logic [1:0]      status;
    logic            found;
    logic [TagW-1:0] tag;
    logic            is_empty;
    logic [8:0]      total;
  } slot_result_t;

  class slot_bank_scoreboard;
    logic [TagW-1:0]  tag_q[NumSlots][SlotDepth];
    logic [PrioW-1:0] prio_q[NumSlots][SlotDepth];
    logic [TimeW-1:0] due_q[NumSlots][SlotDepth];
    int               fill[NumSlots];
    int               total;
    logic [PrioW-1:0] top_prio;
    logic [PrioW-1:0] bot_prio;
    slot_result_t     awaited[$];
    int               errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      total = 0;
      top_prio = 4'd15;
      bot_prio = 4'd0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [PrioW-1:0] val);
      if (idx == CFG_TOP) top_prio = val;
      else bot_prio = val;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_op(logic [2:0] op, logic [3:0] s, logic [TagW-1:0] tg,
                          logic [PrioW-1:0] pr, logic [TimeW-1:0] due);
      slot_result_t r;
      int pos;
      int best;
      r = '{ST_OK, 1'b0, '0, 1'b0, 9'd0};
      if (op == OP_INSERT) begin
        if (fill[s] >= SlotDepth) begin
          r.status = ST_FULL;
        end else begin
          if (pr == top_prio) pos = fill[s];
          else if (pr == bot_prio) pos = 0;
          else begin
            pos = 0;
            while (pos < fill[s] && !(pr < prio_q[s][pos])) pos++;
          end
          for (int k = fill[s]; k > pos; k--) begin
            tag_q[s][k]  = tag_q[s][k-1];
            prio_q[s][k] = prio_q[s][k-1];
            due_q[s][k]  = due_q[s][k-1];
          end
          tag_q[s][pos] = tg;
          prio_q[s][pos] = pr;
          due_q[s][pos] = due;
          fill[s]++;
          total++;
        end
      end else if (op == OP_CLEAR) begin
        total -= fill[s];
        fill[s] = 0;
      end else if (op == OP_CLRALL) begin
        foreach (fill[i]) fill[i] = 0;
        total = 0;
      end else if (op == OP_NEAR) begin
        for (int i = 0; i < NumSlots; i++) begin
          if (fill[i] != 0) begin
            best = 0;
            for (int k = 1; k < fill[i]; k++)
              if (due_q[i][k] < due_q[i][best]) best = k;
            r.found = 1'b1;
            r.tag = tag_q[i][best];
            break;
          end
        end
      end else if (op == OP_EMPTY) begin
        r.is_empty = (fill[s] == 0);
      end
      r.total = total[8:0];
      awaited = {awaited, r};
    endfunction

    function void check_result(slot_result_t got);
      slot_result_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.found !== e.found) begin
        $error("found exp %0d got %0d", e.found, got.found); errors++;
      end
      if (got.tag !== e.tag) begin
        $error("nearest_tag exp %0h got %0h", e.tag, got.tag); errors++;
      end
      if (got.is_empty !== e.is_empty) begin
        $error("slot_is_empty exp %0d got %0d", e.is_empty, got.is_empty); errors++;
      end
      if (got.total !== e.total) begin
        $error("total_count exp %0d got %0d", e.total, got.total); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_TOP;
  logic [PrioW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = OP_INSERT;
  logic [3:0] slot_index = '0;
  logic [TagW-1:0] task_tag = '0;
  logic [PrioW-1:0] task_priority = '0;
  logic [TimeW-1:0] due_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic found;
  logic [TagW-1:0] nearest_tag;
  logic slot_is_empty;
  logic [8:0] total_count;

  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  slot_bank_scoreboard sb = new();

  timing_wheel_priority_slots_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("** timing_wheel_priority_slots_core: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, found, nearest_tag, slot_is_empty, total_count});
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (rst || quiet || $urandom_range(3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_op(logic [2:0] op, logic [3:0] s, logic [TagW-1:0] tg,
                         logic [PrioW-1:0] pr, logic [TimeW-1:0] due);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    slot_index <= s;
    task_tag <= tg;
    task_priority <= pr;
    due_time <= due;
    do @(posedge clk); while (!in_ready);
    sb.note_op(op, s, tg, pr, due);
    if (!quiet && $urandom_range(3) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [PrioW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int r;
    logic [3:0] s;
    r = $urandom_range(99);
    s = ($urandom_range(1) != 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    if (r < 56) send_op(OP_INSERT, s, 16'($urandom), 4'($urandom), $urandom);
    else if (r < 72) send_op(OP_NEAR, s, 16'($urandom), 4'($urandom), $urandom);
    else if (r < 84) send_op(OP_EMPTY, s, 16'($urandom), 4'($urandom), $urandom);
    else if (r < 93) send_op(OP_CLEAR, s, 16'($urandom), 4'($urandom), $urandom);
    else if (r < 96) send_op(OP_CLRALL, s, 16'($urandom), 4'($urandom), $urandom);
    else send_op(3'($urandom_range(OpSpareLo, OpSpareHi)), s, 16'($urandom), 4'($urandom),
                 $urandom);
  endtask

  initial begin
    logic [PrioW-1:0] tops[6] = '{4'd15, 4'd0, 4'd7, 4'd0, 4'd15, 4'd9};
    logic [PrioW-1:0] bots[6] = '{4'd0, 4'd15, 4'd7, 4'd0, 4'd15, 4'd3};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_op(OP_NEAR, 4'd0, '0, '0, '0);
    send_op(OP_EMPTY, 4'd15, '1, '1, '1);
    for (int k = 0; k < SlotDepth + 1; k++)
      send_op(OP_INSERT, 4'd5, (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(k * 16'h1111),
              4'(k), (k == 2) ? 32'hFFFF_FFFF : (k == 9) ? 32'h0 : $urandom);
    send_op(OP_NEAR, 4'd0, '0, '0, '0);
    send_op(OP_EMPTY, 4'd5, '0, '0, '0);
    send_op(OP_CLEAR, 4'd5, '0, '0, '0);
    send_op(OP_CLRALL, 4'd0, '0, '0, '0);
    for (logic [2:0] op = OpSpareLo; op != 3'd0; op++)
      send_op(op, 4'd2, '1, '1, '1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_TOP, tops[ph]);
      write_reg(CFG_BOT, bots[ph]);
      quiet = (ph == 5);
      if (ph == 1) hold_request = 1'b1;
      repeat (320) random_op();
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** timing_wheel_priority_slots_core: PASSED **");
    else
      $display("** timing_wheel_priority_slots_core: FAILED **");
    $finish;
  end
endmodule

// ===== timing_wheel_priority_slots_core.f =====
+incdir+hdl
hdl/twps_pkg.sv
hdl/twps_ram.sv
hdl/twps_front.sv
hdl/twps_back.sv
hdl/timing_wheel_priority_slots_core.sv
bench/tb.sv
